FILE: hw/rtl/fgde_pkg.sv
// fgde_pkg: shared widths, payload types, status codes and the cordic angle table
// for the field gradient direction estimator; depends on nothing
package fgde_pkg;

	localparam int DEPTH        = 512;
	localparam int ADDR_W       = $clog2(DEPTH);
	localparam int CNT_W        = $clog2(DEPTH + 1);
	localparam int FW           = 24;
	localparam int DW           = FW + 1;
	localparam int SW           = 64;
	localparam int MW           = 72;
	localparam int PW           = 2 * MW;
	localparam int NORM_W       = 30;
	localparam int CW           = 34;
	localparam int ZW           = 32;
	localparam int AW           = 16;
	localparam int CORDIC_STEPS = 24;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int ROUND_SH     = 11;
	localparam logic signed [ZW-1:0] PI_Z      = 32'sd52707179;
	localparam logic signed [ZW-1:0] ROUND_ADD = 32'sd1024;
	localparam logic signed [AW-1:0] ANGLE_MAX = 16'sd25736;

	localparam logic REQ_STORE  = 1'b0;
	localparam logic REQ_SOLVE  = 1'b1;
	localparam logic METHOD_LSQ = 1'b0;
	localparam logic METHOD_EXT = 1'b1;

	typedef enum logic [2:0] {
		ST_SOLVED   = 3'd0,
		ST_FEW      = 3'd1,
		ST_SINGULAR = 3'd2,
		ST_STORED   = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef struct packed {
		logic                 req_type;
		logic signed [FW-1:0] pos_x;
		logic signed [FW-1:0] pos_y;
		logic signed [FW-1:0] measurement;
	} req_t;

	typedef struct packed {
		logic signed [AW-1:0] angle;
		logic [2:0]           status;
	} rsp_t;

	typedef struct packed {
		logic signed [FW-1:0] x;
		logic signed [FW-1:0] y;
		logic signed [FW-1:0] m;
	} sample_t;

	typedef struct packed {
		logic                 start;
		logic signed [MW-1:0] a;
		logic signed [MW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [PW-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic                 start;
		logic signed [PW-1:0] gx;
		logic signed [PW-1:0] gy;
	} ang_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [AW-1:0] angle;
	} ang_rsp_t;

	// atan(2^-i) in units of 2^-24 rad
	function automatic logic [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
		logic [ZW-1:0] v;
		case (i)
			5'd0:    v = 32'd13176795;
			5'd1:    v = 32'd7778716;
			5'd2:    v = 32'd4110060;
			5'd3:    v = 32'd2086331;
			5'd4:    v = 32'd1047214;
			5'd5:    v = 32'd524117;
			5'd6:    v = 32'd262123;
			5'd7:    v = 32'd131069;
			5'd8:    v = 32'd65536;
			5'd9:    v = 32'd32768;
			5'd10:   v = 32'd16384;
			5'd11:   v = 32'd8192;
			5'd12:   v = 32'd4096;
			5'd13:   v = 32'd2048;
			5'd14:   v = 32'd1024;
			5'd15:   v = 32'd512;
			5'd16:   v = 32'd256;
			5'd17:   v = 32'd128;
			5'd18:   v = 32'd64;
			5'd19:   v = 32'd32;
			5'd20:   v = 32'd16;
			5'd21:   v = 32'd8;
			5'd22:   v = 32'd4;
			5'd23:   v = 32'd2;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/fgde_if.sv
// fgde_if: valid/ready channel interfaces for requests, results and the method register
// depends on fgde_pkg
interface fgde_req_if;
	logic           valid;
	logic           ready;
	fgde_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fgde_rsp_if;
	logic           valid;
	logic           ready;
	fgde_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fgde_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/field_gradient_direction_estimator_top.sv
// field_gradient_direction_estimator_top: sample memory, solve sequencer and result register
// depends on fgde_pkg, fgde_if, fgde_mul and fgde_angle
//
// usage
//   req  : sample or solve requests (req_type, pos_x, pos_y, measurement)
//   rsp  : one result (angle, status) for every request, held until taken
//   cfg  : method_select, written while the block is idle; ready is always high
// a sample request writes the sample memory in the cycle it is accepted and its
// result (stored, or store full) is valid in the next cycle
// a solve request walks the stored samples except the newest, one memory read
// per sample; least squares spends five serial multiplies per sample, then
// sixteen serial multiplies build the centred sums, the determinant and the
// gradient, then up to 114 scaling shifts and 24 cordic steps give the angle
// each serial multiply steps through its second operand until no set bit is left;
// a solve with too few samples is answered in the next cycle
// a solve always empties the store
// reset clears the sample count, the method register and the result valid flag;
// the memory itself is never cleared, entries past the count are not read
// while the receiver stalls the finished result waits in the output register
// and no new request is accepted until it is taken or taken in the same cycle
module field_gradient_direction_estimator_top (
	input logic         clk,
	input logic         arst_n,
	fgde_req_if.sink    req,
	fgde_rsp_if.source  rsp,
	fgde_cfg_if.sink    cfg
);
	import fgde_pkg::*;

	// one-hot sequencer states
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_RD    = 10'b0000000010,
		S_LD    = 10'b0000000100,
		S_SMUL  = 10'b0000001000,
		S_SWAIT = 10'b0000010000,
		S_CMUL  = 10'b0000100000,
		S_CWAIT = 10'b0001000000,
		S_ANG   = 10'b0010000000,
		S_AWAIT = 10'b0100000000,
		S_SPARE = 10'b1000000000
	} state_t;

	// sample memory, read data registered
	sample_t mem [DEPTH];
	sample_t rd_q;

	state_t              state_q;
	logic                method_q;
	logic [CNT_W-1:0]    count_q;
	logic                out_valid_q;
	rsp_t                out_q;
	logic [ADDR_W-1:0]   n_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [3:0]          kop_q;
	logic signed [FW-1:0] xe_q;
	logic signed [FW-1:0] ye_q;
	logic signed [DW-1:0] dx_q;
	logic signed [DW-1:0] dy_q;
	logic signed [FW-1:0] m_q;
	logic signed [SW-1:0] sxx_q, sxy_q, syy_q, sxm_q, sym_q, sx_q, sy_q, sm_q;
	logic signed [MW-1:0] p_q, q_q, r_q, u_q, v_q;
	logic signed [PW-1:0] t_q, det_q, gx_q, gy_q;
	logic signed [FW-1:0] max_m_q, max_x_q, max_y_q, min_m_q, min_x_q, min_y_q;

	logic                 in_ready;
	logic                 accept;
	logic                 mem_we;
	logic [ADDR_W-1:0]    n_new;
	logic                 few;
	logic                 last;
	logic signed [DW-1:0] dx_c;
	logic signed [DW-1:0] dy_c;
	logic signed [PW-1:0] diff;
	logic signed [MW-1:0] n_ext;
	mul_req_t             mreq;
	mul_rsp_t             mrsp;
	ang_req_t             areq;
	ang_rsp_t             arsp;

	// a request is taken only when idle and the result register is free
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign accept   = req.valid && in_ready;
	assign mem_we   = accept && (req.data.req_type == REQ_STORE)
		&& (count_q != CNT_W'(DEPTH));
	// the newest sample is left out of the solve
	assign n_new    = (count_q == '0) ? '0 : ADDR_W'(count_q - 1'b1);
	assign few      = (method_q == METHOD_EXT) ? (n_new < ADDR_W'(2)) : (n_new < ADDR_W'(3));
	assign last     = idx_q == ADDR_W'(n_q - 1'b1);
	assign dx_c     = DW'(rd_q.x) - DW'(xe_q);
	assign dy_c     = DW'(rd_q.y) - DW'(ye_q);
	assign diff     = t_q - mrsp.prod;
	assign n_ext    = MW'(signed'({1'b0, n_q}));

	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[ADDR_W-1:0]] <= '{x: req.data.pos_x, y: req.data.pos_y,
				m: req.data.measurement};
		end
		rd_q <= mem[idx_q];
	end

	// multiplier operand selection: per-sample products, then the solve chain
	always_comb begin
		mreq.start = (state_q == S_SMUL) || (state_q == S_CMUL);
		mreq.a     = '0;
		mreq.b     = '0;
		if (state_q == S_SMUL) begin
			case (kop_q)
				4'd0:    begin mreq.a = MW'(dx_q); mreq.b = MW'(dx_q); end
				4'd1:    begin mreq.a = MW'(dx_q); mreq.b = MW'(dy_q); end
				4'd2:    begin mreq.a = MW'(dy_q); mreq.b = MW'(dy_q); end
				4'd3:    begin mreq.a = MW'(dx_q); mreq.b = MW'(m_q); end
				default: begin mreq.a = MW'(dy_q); mreq.b = MW'(m_q); end
			endcase
		end else begin
			// even steps load the minuend, odd steps subtract
			case (kop_q)
				4'd0:    begin mreq.a = n_ext;      mreq.b = MW'(sxx_q); end
				4'd1:    begin mreq.a = MW'(sx_q);  mreq.b = MW'(sx_q);  end
				4'd2:    begin mreq.a = n_ext;      mreq.b = MW'(sxy_q); end
				4'd3:    begin mreq.a = MW'(sx_q);  mreq.b = MW'(sy_q);  end
				4'd4:    begin mreq.a = n_ext;      mreq.b = MW'(syy_q); end
				4'd5:    begin mreq.a = MW'(sy_q);  mreq.b = MW'(sy_q);  end
				4'd6:    begin mreq.a = n_ext;      mreq.b = MW'(sxm_q); end
				4'd7:    begin mreq.a = MW'(sx_q);  mreq.b = MW'(sm_q);  end
				4'd8:    begin mreq.a = n_ext;      mreq.b = MW'(sym_q); end
				4'd9:    begin mreq.a = MW'(sy_q);  mreq.b = MW'(sm_q);  end
				4'd10:   begin mreq.a = p_q;        mreq.b = r_q;        end
				4'd11:   begin mreq.a = q_q;        mreq.b = q_q;        end
				4'd12:   begin mreq.a = u_q;        mreq.b = r_q;        end
				4'd13:   begin mreq.a = v_q;        mreq.b = q_q;        end
				4'd14:   begin mreq.a = p_q;        mreq.b = v_q;        end
				default: begin mreq.a = q_q;        mreq.b = u_q;        end
			endcase
		end
	end

	// extreme-point mode feeds the position difference straight to the angle unit
	always_comb begin
		areq.start = state_q == S_ANG;
		if (method_q == METHOD_EXT) begin
			areq.gx = PW'(DW'(max_x_q) - DW'(min_x_q));
			areq.gy = PW'(DW'(max_y_q) - DW'(min_y_q));
		end else begin
			areq.gx = gx_q;
			areq.gy = gy_q;
		end
	end

	fgde_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	fgde_angle u_angle (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (areq),
		.rsp    (arsp)
	);

	// control: sequencer, sample count, method register, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			method_q    <= METHOD_LSQ;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				method_q <= cfg.data;
			end
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.data.req_type == REQ_STORE) begin
							out_valid_q <= 1'b1;
							if (mem_we) begin
								count_q <= count_q + 1'b1;
							end
						end else begin
							count_q <= '0;
							if (few) begin
								out_valid_q <= 1'b1;
							end else begin
								state_q <= S_RD;
							end
						end
					end
				end
				S_RD: state_q <= S_LD;
				S_LD: begin
					if (method_q == METHOD_LSQ) begin
						state_q <= S_SMUL;
					end else if (last) begin
						state_q <= S_ANG;
					end else begin
						state_q <= S_RD;
					end
				end
				S_SMUL: state_q <= S_SWAIT;
				S_SWAIT: begin
					if (mrsp.done) begin
						if (kop_q != 4'd4) begin
							state_q <= S_SMUL;
						end else if (last) begin
							state_q <= S_CMUL;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_CMUL: state_q <= S_CWAIT;
				S_CWAIT: begin
					if (mrsp.done) begin
						if (kop_q != 4'd15) begin
							state_q <= S_CMUL;
						end else if (det_q == '0) begin
							state_q     <= S_IDLE;
							out_valid_q <= 1'b1;
						end else begin
							state_q <= S_ANG;
						end
					end
				end
				S_ANG: state_q <= S_AWAIT;
				S_AWAIT: begin
					if (arsp.done) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q   <= n_new;
				idx_q <= '0;
				xe_q  <= req.data.pos_x;
				ye_q  <= req.data.pos_y;
				sxx_q <= '0; sxy_q <= '0; syy_q <= '0; sxm_q <= '0;
				sym_q <= '0; sx_q  <= '0; sy_q  <= '0; sm_q  <= '0;
				if (accept) begin
					out_q.angle <= '0;
					if (req.data.req_type == REQ_STORE) begin
						out_q.status <= mem_we ? ST_STORED : ST_FULL;
					end else begin
						out_q.status <= ST_FEW;
					end
				end
			end
			S_LD: begin
				dx_q  <= dx_c;
				dy_q  <= dy_c;
				m_q   <= rd_q.m;
				kop_q <= '0;
				sx_q  <= sx_q + SW'(dx_c);
				sy_q  <= sy_q + SW'(dy_c);
				sm_q  <= sm_q + SW'(rd_q.m);
				// first holder of the largest and of the smallest reading wins
				if (idx_q == '0 || rd_q.m > max_m_q) begin
					max_m_q <= rd_q.m; max_x_q <= rd_q.x; max_y_q <= rd_q.y;
				end
				if (idx_q == '0 || rd_q.m < min_m_q) begin
					min_m_q <= rd_q.m; min_x_q <= rd_q.x; min_y_q <= rd_q.y;
				end
				if (method_q == METHOD_EXT && !last) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_SWAIT: begin
				if (mrsp.done) begin
					case (kop_q)
						4'd0:    sxx_q <= sxx_q + SW'(mrsp.prod);
						4'd1:    sxy_q <= sxy_q + SW'(mrsp.prod);
						4'd2:    syy_q <= syy_q + SW'(mrsp.prod);
						4'd3:    sxm_q <= sxm_q + SW'(mrsp.prod);
						default: sym_q <= sym_q + SW'(mrsp.prod);
					endcase
					if (kop_q != 4'd4) begin
						kop_q <= kop_q + 1'b1;
					end else begin
						kop_q <= '0;
						if (!last) begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
			end
			S_CWAIT: begin
				if (mrsp.done) begin
					kop_q <= kop_q + 1'b1;
					if (!kop_q[0]) begin
						t_q <= mrsp.prod;
					end else begin
						case (kop_q[3:1])
							3'd0:    p_q   <= MW'(diff);
							3'd1:    q_q   <= MW'(diff);
							3'd2:    r_q   <= MW'(diff);
							3'd3:    u_q   <= MW'(diff);
							3'd4:    v_q   <= MW'(diff);
							3'd5:    det_q <= diff;
							3'd6:    gx_q  <= diff;
							default: gy_q  <= diff;
						endcase
					end
					if (kop_q == 4'd15 && det_q == '0) begin
						out_q.angle  <= '0;
						out_q.status <= ST_SINGULAR;
					end
				end
			end
			S_AWAIT: begin
				if (arsp.done) begin
					out_q.angle  <= arsp.angle;
					out_q.status <= ST_SOLVED;
				end
			end
			default: ;
		endcase
	end
endmodule

FILE: hw/rtl/fgde_mul.sv
// fgde_mul: shared signed shift-add multiplier, one partial product per cycle
// depends on fgde_pkg
module fgde_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  fgde_pkg::mul_req_t req,
	output fgde_pkg::mul_rsp_t rsp
);
	import fgde_pkg::*;

	logic          busy_q;
	logic          done_q;
	logic          neg_q;
	logic [PW-1:0] a_q;
	logic [MW-1:0] b_q;
	logic [PW-1:0] acc_q;
	logic [PW-1:0] prod_q;
	logic [MW-1:0] a_abs;
	logic [MW-1:0] b_abs;
	logic          last;

	assign a_abs = req.a[MW-1] ? MW'(-req.a) : MW'(req.a);
	assign b_abs = req.b[MW-1] ? MW'(-req.b) : MW'(req.b);
	assign last  = busy_q && (b_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= last;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= {{(PW-MW){1'b0}}, a_abs};
			b_q   <= b_abs;
			acc_q <= '0;
			neg_q <= req.a[MW-1] ^ req.b[MW-1];
		end else if (last) begin
			prod_q <= neg_q ? -acc_q : acc_q;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = signed'(prod_q);
endmodule

FILE: hw/rtl/fgde_angle.sv
// fgde_angle: scales a wide vector to 30 bits and runs a vectoring cordic,
// one shift or one micro-rotation per cycle; depends on fgde_pkg
module fgde_angle (
	input  logic               clk,
	input  logic               arst_n,
	input  fgde_pkg::ang_req_t req,
	output fgde_pkg::ang_rsp_t rsp
);
	import fgde_pkg::*;

	typedef enum logic [4:0] {
		A_IDLE  = 5'b00001,
		A_NORM  = 5'b00010,
		A_FOLD  = 5'b00100,
		A_ITER  = 5'b01000,
		A_ROUND = 5'b10000
	} ang_state_t;

	ang_state_t             state_q;
	logic                   done_q;
	logic [PW-1:0]          mx_q;
	logic [PW-1:0]          my_q;
	logic                   negx_q;
	logic                   negy_q;
	logic                   zero_q;
	logic signed [CW-1:0]   x_q;
	logic signed [CW-1:0]   y_q;
	logic signed [ZW-1:0]   z_q;
	logic [STEP_W-1:0]      i_q;
	logic signed [AW-1:0]   angle_q;
	logic                   big;
	logic signed [CW-1:0]   xs;
	logic signed [CW-1:0]   ys;
	logic signed [CW-1:0]   dx;
	logic signed [CW-1:0]   dy;
	logic signed [ZW-1:0]   zr;
	logic signed [ZW-1:0]   zs;
	logic signed [AW-1:0]   ang_c;

	assign big = (|mx_q[PW-1:NORM_W]) || (|my_q[PW-1:NORM_W]);
	assign xs  = negx_q ? -CW'(mx_q[NORM_W-1:0]) : CW'(mx_q[NORM_W-1:0]);
	assign ys  = negy_q ? -CW'(my_q[NORM_W-1:0]) : CW'(my_q[NORM_W-1:0]);
	assign dx  = x_q >>> i_q;
	assign dy  = y_q >>> i_q;
	assign zr  = z_q + ROUND_ADD;
	assign zs  = zr >>> ROUND_SH;

	always_comb begin
		if (zs > ZW'(ANGLE_MAX)) begin
			ang_c = ANGLE_MAX;
		end else if (zs < -ZW'(ANGLE_MAX)) begin
			ang_c = -ANGLE_MAX;
		end else begin
			ang_c = AW'(zs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE:  if (req.start) state_q <= A_NORM;
				A_NORM:  if (!big) state_q <= A_FOLD;
				A_FOLD:  state_q <= A_ITER;
				A_ITER:  if (i_q == STEP_W'(CORDIC_STEPS - 1)) state_q <= A_ROUND;
				A_ROUND: begin
					state_q <= A_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				mx_q   <= req.gx[PW-1] ? PW'(-req.gx) : PW'(req.gx);
				my_q   <= req.gy[PW-1] ? PW'(-req.gy) : PW'(req.gy);
				negx_q <= req.gx[PW-1];
				negy_q <= req.gy[PW-1];
			end
			A_NORM: begin
				if (big) begin
					mx_q <= mx_q >> 1;
					my_q <= my_q >> 1;
				end
			end
			A_FOLD: begin
				zero_q <= (mx_q[NORM_W-1:0] == '0) && (my_q[NORM_W-1:0] == '0);
				i_q    <= '0;
				if (xs < 0) begin
					// left half plane: turn by half a circle first
					z_q <= (ys >= 0) ? PI_Z : -PI_Z;
					x_q <= -xs;
					y_q <= -ys;
				end else begin
					z_q <= '0;
					x_q <= xs;
					y_q <= ys;
				end
			end
			A_ITER: begin
				i_q <= i_q + 1'b1;
				if (y_q > 0) begin
					x_q <= x_q + dy;
					y_q <= y_q - dx;
					z_q <= z_q + signed'(atan_entry(i_q));
				end else begin
					x_q <= x_q - dy;
					y_q <= y_q + dx;
					z_q <= z_q - signed'(atan_entry(i_q));
				end
			end
			A_ROUND: angle_q <= zero_q ? '0 : ang_c;
			default: ;
		endcase
	end

	assign rsp.done  = done_q;
	assign rsp.angle = angle_q;
endmodule

FILE: hw/rtl/fgde_checker.sv
// fgde_checker: port-level assertions for the estimator top, attached by bind
// depends on fgde_pkg and field_gradient_direction_estimator_top
module fgde_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  req_type,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic signed [15:0]    angle,
	input logic [2:0]            status
);
	import fgde_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(angle) && $stable(status))
		else $error("result dropped or changed while stalled");

	// a sample request is answered in the next cycle
	a_store_lat: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_type == REQ_STORE |=> rsp_valid
		&& (status == ST_STORED || status == ST_FULL))
		else $error("sample request not answered in one cycle");

	// only a solved result carries an angle
	a_angle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_SOLVED |-> angle == '0)
		else $error("angle set on unsolved result");

	// angle stays within plus or minus pi
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> angle <= ANGLE_MAX && angle >= -ANGLE_MAX)
		else $error("angle out of range");
endmodule

bind field_gradient_direction_estimator_top fgde_checker u_fgde_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_type  (req.data.req_type),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.angle     (rsp.data.angle),
	.status    (rsp.data.status)
);

FILE: sim/field_gradient_direction_estimator_top_tb.sv
// field_gradient_direction_estimator_top_tb: self-checking bench for the gradient direction block
// depends on fgde_pkg, fgde_if and field_gradient_direction_estimator_top
module field_gradient_direction_estimator_top_tb;
	import fgde_pkg::*;

	typedef logic signed [191:0] wide_t;

	// one pending operation: a request, or a write of the method register
	typedef struct {
		bit   is_cfg;
		req_t rq;
		bit   method;
	} pending_op_t;

	typedef struct {
		logic signed [AW-1:0] angle;
		status_t              status;
	} answer_t;

	localparam int WATCHDOG_LIMIT = 250000;

	logic clk = 1'b0;
	logic arst_n;

	fgde_req_if req_ch ();
	fgde_rsp_if rsp_ch ();
	fgde_cfg_if cfg_ch ();

	field_gradient_direction_estimator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// shadow copy of the sample memory and the method register
	int          shadow_x [DEPTH];
	int          shadow_y [DEPTH];
	int          shadow_m [DEPTH];
	int          shadow_count = 0;
	bit          shadow_method = METHOD_LSQ;

	pending_op_t op_queue [$];
	answer_t     answer_queue [$];
	int          total_ops = 0;
	int          ops_done = 0;
	int          seen_done = 0;
	int          error_count = 0;
	int          quiet_cycles = 0;
	int          idle_cycles = 0;
	bit          hold_started = 1'b0;
	int          hold_left = 0;
	int          send_idle_pct;
	int          recv_idle_pct;

	// clock, period 8
	always #4 clk = ~clk;

	// vectoring cordic, angle in units of 2^-24 rad, rounded to q2.13
	function automatic logic signed [AW-1:0] cordic_direction(input longint xi, input longint yi);
		longint x, y, z, dx, dy, r;
		x = xi;
		y = yi;
		z = 0;
		if (x == 0 && y == 0)
			return '0;
		if (x < 0) begin
			z = (y >= 0) ? longint'(PI_Z) : -longint'(PI_Z);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y > 0) begin
				x = x + dy;
				y = y - dx;
				z = z + longint'(atan_entry(i[STEP_W-1:0]));
			end else begin
				x = x - dy;
				y = y + dx;
				z = z - longint'(atan_entry(i[STEP_W-1:0]));
			end
		end
		r = (z + 1024) >>> ROUND_SH;
		if (r > ANGLE_MAX)
			r = ANGLE_MAX;
		if (r < -ANGLE_MAX)
			r = -ANGLE_MAX;
		return r[AW-1:0];
	endfunction

	// scale both wide components by a common shift until they fit in 30 bits
	function automatic logic signed [AW-1:0] wide_direction(input wide_t gx, input wide_t gy);
		wide_t  mx, my, tx, ty;
		int     bx, by, bl, s;
		longint x, y;
		mx = gx[191] ? -gx : gx;
		my = gy[191] ? -gy : gy;
		bx = 0;
		by = 0;
		for (int i = 0; i < 192; i++) begin
			if (mx[i])
				bx = i + 1;
			if (my[i])
				by = i + 1;
		end
		bl = (bx > by) ? bx : by;
		s  = (bl > NORM_W) ? bl - NORM_W : 0;
		tx = mx >> s;
		ty = my >> s;
		x  = longint'(tx[30:0]);
		y  = longint'(ty[30:0]);
		if (gx[191])
			x = -x;
		if (gy[191])
			y = -y;
		return cordic_direction(x, y);
	endfunction

	// plane fit through the normal equations, gradient from cramer's rule
	function automatic answer_t plane_fit_answer(input int n, input longint xe, input longint ye);
		answer_t a;
		longint  dx, dy, mm, sxx, sxy, syy, sx, sy, sxm, sym, sm;
		wide_t   p, q, r, u, v, det;
		a.angle  = '0;
		a.status = ST_FEW;
		if (n < 3)
			return a;
		sxx = 0; sxy = 0; syy = 0; sx = 0; sy = 0; sxm = 0; sym = 0; sm = 0;
		for (int i = 0; i < n; i++) begin
			dx  = longint'(shadow_x[i]) - xe;
			dy  = longint'(shadow_y[i]) - ye;
			mm  = shadow_m[i];
			sxx += dx * dx; sxy += dx * dy; syy += dy * dy;
			sx  += dx; sy += dy; sxm += dx * mm; sym += dy * mm; sm += mm;
		end
		p   = wide_t'(n) * wide_t'(sxx) - wide_t'(sx) * wide_t'(sx);
		q   = wide_t'(n) * wide_t'(sxy) - wide_t'(sx) * wide_t'(sy);
		r   = wide_t'(n) * wide_t'(syy) - wide_t'(sy) * wide_t'(sy);
		u   = wide_t'(n) * wide_t'(sxm) - wide_t'(sx) * wide_t'(sm);
		v   = wide_t'(n) * wide_t'(sym) - wide_t'(sy) * wide_t'(sm);
		det = p * r - q * q;
		if (det == 0) begin
			a.status = ST_SINGULAR;
			return a;
		end
		a.angle  = wide_direction(u * r - v * q, p * v - q * u);
		a.status = ST_SOLVED;
		return a;
	endfunction

	// position of the first largest reading minus that of the first smallest
	function automatic answer_t extreme_answer(input int n);
		answer_t a;
		int      imax, imin;
		a.angle  = '0;
		a.status = ST_FEW;
		if (n < 2)
			return a;
		imax = 0;
		imin = 0;
		for (int i = 1; i < n; i++) begin
			if (shadow_m[i] > shadow_m[imax])
				imax = i;
			if (shadow_m[i] < shadow_m[imin])
				imin = i;
		end
		a.angle  = cordic_direction(longint'(shadow_x[imax]) - shadow_x[imin],
			longint'(shadow_y[imax]) - shadow_y[imin]);
		a.status = ST_SOLVED;
		return a;
	endfunction

	// applies one request to the shadow state and returns its answer
	function automatic answer_t next_answer(input req_t rq);
		answer_t a;
		int      n;
		a.angle = '0;
		if (rq.req_type == REQ_STORE) begin
			if (shadow_count >= DEPTH) begin
				a.status = ST_FULL;
			end else begin
				shadow_x[shadow_count] = rq.pos_x;
				shadow_y[shadow_count] = rq.pos_y;
				shadow_m[shadow_count] = rq.measurement;
				shadow_count++;
				a.status = ST_STORED;
			end
		end else begin
			// the newest sample is left out of every solve
			n = (shadow_count > 0) ? shadow_count - 1 : 0;
			if (shadow_method == METHOD_EXT)
				a = extreme_answer(n);
			else
				a = plane_fit_answer(n, rq.pos_x, rq.pos_y);
			shadow_count = 0;
		end
		return a;
	endfunction

	function automatic void push_request(input bit t, input int x, input int y, input int m);
		pending_op_t op;
		op.is_cfg            = 1'b0;
		op.method            = 1'b0;
		op.rq.req_type       = t;
		op.rq.pos_x          = x[FW-1:0];
		op.rq.pos_y          = y[FW-1:0];
		op.rq.measurement    = m[FW-1:0];
		op_queue.push_back(op);
	endfunction

	function automatic void push_method(input bit mth);
		pending_op_t op;
		op.is_cfg = 1'b1;
		op.method = mth;
		op.rq     = '0;
		op_queue.push_back(op);
	endfunction

	// a random coordinate or reading in one of several ranges
	function automatic int pick_value(input int style);
		case (style)
			0:       return $signed($urandom_range(0, 32'hFFFFFF) << 8) >>> 8;
			1:       return $signed($urandom_range(0, 4000)) - 2000;
			default: return $signed($urandom_range(0, 40)) - 20;
		endcase
	endfunction

	// a burst of samples closed by a solve; a fixed x gives collinear sets, fixed readings flat ones
	function automatic void push_burst(input int count);
		int style, xs, ms, fixed_x, fixed_m;
		style   = $urandom_range(0, 2);
		xs      = $urandom_range(0, 5);
		ms      = $urandom_range(0, 5);
		fixed_x = pick_value(style);
		fixed_m = pick_value(style);
		for (int i = 0; i < count; i++)
			push_request(REQ_STORE, (xs == 0) ? fixed_x : pick_value(style),
				pick_value(style), (ms == 0) ? fixed_m : pick_value(style));
		push_request(REQ_SOLVE, pick_value(style), pick_value(style), pick_value(0));
	endfunction

	// stimulus: directed part, then random bursts with method changes in between
	initial begin
		arst_n = 1'b0;

		// least squares: empty store, too few, a good fit, a singular set
		push_method(METHOD_LSQ);
		push_request(REQ_SOLVE, 0, 0, 0);
		push_request(REQ_STORE, 100, 200, 5);
		push_request(REQ_STORE, -300, 50, 9);
		push_request(REQ_STORE, 40, -70, 1);
		push_request(REQ_SOLVE, 0, 0, 0);
		push_request(REQ_STORE, 8388607, -8388608, 8388607);
		push_request(REQ_STORE, -8388608, 8388607, -8388608);
		push_request(REQ_STORE, 8388607, 8388607, 0);
		push_request(REQ_STORE, 0, 0, -1);
		push_request(REQ_STORE, 1, 2, 3);
		push_request(REQ_SOLVE, -8388608, 8388607, 8388607);
		// all samples on one vertical line
		for (int i = 0; i < 5; i++)
			push_request(REQ_STORE, 777, i * 1000, i * 3);
		push_request(REQ_SOLVE, 5, 5, 0);
		// extreme points: too few, ties on the readings
		push_method(METHOD_EXT);
		push_request(REQ_STORE, 10, 10, 4);
		push_request(REQ_STORE, 20, 20, 4);
		push_request(REQ_SOLVE, 0, 0, 0);
		push_request(REQ_STORE, 10, 0, 7);
		push_request(REQ_STORE, 0, 10, 7);
		push_request(REQ_STORE, -10, 5, -7);
		push_request(REQ_STORE, 3, 3, -7);
		push_request(REQ_SOLVE, 0, 0, 0);

		// random part, switching method now and then
		for (int k = 0; k < 60; k++) begin
			if (k % 12 == 0)
				push_method(1'($urandom_range(0, 1)));
			if ($urandom_range(0, 9) == 0)
				push_request(REQ_STORE, pick_value(0), pick_value(0), pick_value(0));
			push_burst(($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12));
		end
		// fill the store to the brim and beyond, solved cheaply by extreme points
		push_method(METHOD_EXT);
		for (int i = 0; i < DEPTH + 3; i++)
			push_request(REQ_STORE, pick_value(1), pick_value(1), pick_value(0));
		push_request(REQ_SOLVE, 0, 0, 0);
		push_method(METHOD_LSQ);
		for (int k = 0; k < 12; k++)
			push_burst($urandom_range(3, 10));
		push_method(METHOD_EXT);
		push_method(METHOD_LSQ);
		push_burst(6);
		total_ops = op_queue.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (op_queue.size() == 0 && answer_queue.size() == 0);
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("field_gradient_direction_estimator_top_tb: clean");
		else
			$display("field_gradient_direction_estimator_top_tb: errors");
		$finish;
	end

	// idling mix follows progress: sender light and receiver heavy, then swapped, then none
	always_comb begin
		if (ops_done < total_ops / 3) begin
			send_idle_pct = 29;
			recv_idle_pct = 83;
		end else if (ops_done < 2 * total_ops / 3) begin
			send_idle_pct = 83;
			recv_idle_pct = 29;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	end

	// driver: requests and register writes change on the falling edge
	always @(negedge clk) begin
		bit taken;
		taken     = (ops_done != seen_done);
		seen_done = ops_done;
		if (arst_n) begin
			if (req_ch.valid && !taken) begin
				// request still on offer, hold it
			end else if (cfg_ch.valid && !taken) begin
				// register write still on offer
			end else if (op_queue.size() == 0) begin
				req_ch.valid <= 1'b0;
				cfg_ch.valid <= 1'b0;
			end else if (op_queue[0].is_cfg) begin
				req_ch.valid <= 1'b0;
				// the method only changes once every answer is back and the block is quiet
				if (answer_queue.size() == 0 && quiet_cycles >= 8) begin
					cfg_ch.valid <= 1'b1;
					cfg_ch.data  <= op_queue[0].method;
				end else begin
					cfg_ch.valid <= 1'b0;
				end
			end else begin
				cfg_ch.valid <= 1'b0;
				if ($urandom_range(0, 99) < send_idle_pct) begin
					req_ch.valid <= 1'b0;
				end else begin
					req_ch.valid <= 1'b1;
					req_ch.data  <= op_queue[0].rq;
				end
			end
		end else begin
			req_ch.valid <= 1'b0;
			req_ch.data  <= '0;
			cfg_ch.valid <= 1'b0;
			cfg_ch.data  <= 1'b0;
		end
	end

	// receiver: random stalls, plus one long hold-off in the middle phase
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_started && ops_done > total_ops / 2) begin
				hold_started = 1'b1;
				hold_left    = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end else begin
			rsp_ch.ready <= 1'b0;
		end
	end

	// acceptance, prediction, checking and the watchdog, all at the rising edge
	always @(posedge clk) begin
		answer_t want;
		bit      moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				shadow_method = cfg_ch.data;
				void'(op_queue.pop_front());
				ops_done++;
				moved = 1'b1;
			end
			if (req_ch.valid && req_ch.ready) begin
				answer_queue.push_back(next_answer(req_ch.data));
				void'(op_queue.pop_front());
				ops_done++;
				moved = 1'b1;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				moved = 1'b1;
				if (answer_queue.size() == 0) begin
					$display("%0t: unexpected result angle %0d status %0d", $realtime,
						rsp_ch.data.angle, rsp_ch.data.status);
					error_count++;
				end else begin
					want = answer_queue.pop_front();
					if (rsp_ch.data.angle !== want.angle) begin
						$display("%0t: angle expected %0d actual %0d", $realtime,
							want.angle, rsp_ch.data.angle);
						error_count++;
					end
					if (rsp_ch.data.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $realtime,
							want.status, rsp_ch.data.status);
						error_count++;
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			idle_cycles  = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("field_gradient_direction_estimator_top_tb: errors");
				$finish;
			end
		end
	end

endmodule
